### src/gpl_pkg.sv
// Shared definitions for the GPIO port register block.
// Register index codes, reset values and controller/datapath link types.
package gpl_pkg;

    localparam int unsigned PIN_COUNT   = 16;
    localparam int unsigned IDX_W       = 3;
    localparam int unsigned BUS_W       = 32;
    localparam int unsigned KEY_BIT     = 16;
    localparam logic [BUS_W-1:0] CFG_RESET = 32'h4444_4444;

    localparam logic [IDX_W-1:0] REG_CFG_LOW  = 3'd0;
    localparam logic [IDX_W-1:0] REG_CFG_HIGH = 3'd1;
    localparam logic [IDX_W-1:0] REG_IN       = 3'd2;
    localparam logic [IDX_W-1:0] REG_OUT      = 3'd3;
    localparam logic [IDX_W-1:0] REG_SETRESET = 3'd4;
    localparam logic [IDX_W-1:0] REG_RESET    = 3'd5;
    localparam logic [IDX_W-1:0] REG_LOCK     = 3'd6;
    localparam logic [IDX_W-1:0] REG_BAD      = 3'd7;

    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    typedef struct packed {
        logic load;          // take a request into the output register
        logic lock_bits_we;  // write low half of lock register
        logic lock_key;      // current lock key
    } t_gpl_cmd;

    typedef struct packed {
        logic bits_match;    // write data low half equals lock bits
    } t_gpl_sts;

endpackage

### src/gpio_port_registers_with_lock.sv
// A response is registered and appears in the cycle after its request is accepted.
// Throughput: one request per cycle; the single response register stalls
// the input only while a finished response is held by downstream stall.
// Reset (synchronous, active low): config words 0x44444444, output data,
// lock bits, lock key and sequence cleared; no response pending.
// Top level of the GPIO port: joins gpl_ctrl and gpl_datapath; uses gpl_pkg.
module gpio_port_registers_with_lock (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_mode,
    input  logic [gpl_pkg::IDX_W-1:0]       i_reg_index,
    input  logic [gpl_pkg::BUS_W-1:0]       i_write_data,
    input  logic [gpl_pkg::PIN_COUNT-1:0]   i_pin_levels_in,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [gpl_pkg::BUS_W-1:0]       o_read_data,
    output logic [gpl_pkg::PIN_COUNT-1:0]   o_pin_drive_out,
    output logic                            o_lock_active,
    output logic                            o_bad_register
);
    import gpl_pkg::*;

    t_gpl_cmd cmd;
    t_gpl_sts sts;

    gpl_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_out_stall   (i_out_stall),
        .i_mode        (i_mode),
        .i_reg_index   (i_reg_index),
        .i_key_bit     (i_write_data[KEY_BIT]),
        .i_sts         (sts),
        .o_cmd         (cmd),
        .o_in_stall    (o_in_stall),
        .o_out_valid   (o_out_valid),
        .o_lock_active (o_lock_active)
    );

    gpl_datapath u_dp (
        .i_clk           (i_clk),
        .i_cmd           (cmd),
        .i_rst_n         (i_rst_n),
        .i_mode          (i_mode),
        .i_reg_index     (i_reg_index),
        .i_write_data    (i_write_data),
        .i_pin_levels_in (i_pin_levels_in),
        .o_sts           (sts),
        .o_read_data     (o_read_data),
        .o_pin_drive_out (o_pin_drive_out),
        .o_bad_register  (o_bad_register)
    );

endmodule

### src/gpl_ctrl.sv
// Lock key sequencer and output handshake control for the GPIO port.
// Depends on gpl_pkg; drives commands into gpl_datapath.
module gpl_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_out_stall,
    input  logic                        i_mode,
    input  logic [gpl_pkg::IDX_W-1:0]   i_reg_index,
    input  logic                        i_key_bit,
    input  gpl_pkg::t_gpl_sts           i_sts,
    output gpl_pkg::t_gpl_cmd           o_cmd,
    output logic                        o_in_stall,
    output logic                        o_out_valid,
    output logic                        o_lock_active
);
    import gpl_pkg::*;

    localparam logic [1:0] STEP_IDLE  = 2'd0;
    localparam logic [1:0] STEP_ONE   = 2'd1;
    localparam logic [1:0] STEP_TWO   = 2'd2;
    localparam logic [1:0] STEP_AWAIT = 2'd3;

    logic [1:0] r_step, n_step;
    logic       r_lock_key, n_lock_key;
    logic       r_out_valid, n_out_valid;
    logic       accept;
    logic       lock_acc;
    logic       lock_wr;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign accept     = i_in_valid & ~o_in_stall;
    assign lock_acc   = accept & (i_reg_index == REG_LOCK);
    assign lock_wr    = lock_acc & (i_mode == MODE_WRITE) & ~r_lock_key;

    always_comb begin
        n_step     = r_step;
        n_lock_key = r_lock_key;
        if (lock_wr) begin
            unique case (r_step)
                STEP_ONE: begin
                    n_step = (!i_key_bit && i_sts.bits_match) ? STEP_TWO
                           : (i_key_bit ? STEP_ONE : STEP_IDLE);
                end
                STEP_TWO: begin
                    n_step = (i_key_bit && i_sts.bits_match) ? STEP_AWAIT
                           : (i_key_bit ? STEP_ONE : STEP_IDLE);
                end
                default: begin
                    n_step = i_key_bit ? STEP_ONE : STEP_IDLE;
                end
            endcase
        end else if (lock_acc && i_mode == MODE_READ) begin
            if (r_step == STEP_AWAIT) begin
                n_lock_key = 1'b1;
            end
            n_step = STEP_IDLE;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (accept) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= STEP_IDLE;
            r_lock_key  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_step      <= n_step;
            r_lock_key  <= n_lock_key;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd.load         = accept;
    assign o_cmd.lock_bits_we = lock_wr;
    assign o_cmd.lock_key     = r_lock_key;
    assign o_out_valid        = r_out_valid;
    assign o_lock_active      = r_lock_key;

    a_key_idle_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lock_key |-> (r_step == STEP_IDLE))
        else $error("lock sequence active after lock");

    a_key_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lock_key |=> r_lock_key)
        else $error("lock key cleared without reset");

    a_key_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_lock_key) |-> $past(lock_acc && i_mode == MODE_READ
                                    && r_step == STEP_AWAIT))
        else $error("lock key set outside sequence");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> r_out_valid)
        else $error("stalled response dropped");

endmodule

### src/gpl_datapath.sv
// Port registers, lock freeze masking, read mux and response register.
// Depends on gpl_pkg; controlled by gpl_ctrl.
module gpl_datapath (
    input  logic                            i_clk,
    input  gpl_pkg::t_gpl_cmd               i_cmd,
    input  logic                            i_rst_n,
    input  logic                            i_mode,
    input  logic [gpl_pkg::IDX_W-1:0]       i_reg_index,
    input  logic [gpl_pkg::BUS_W-1:0]       i_write_data,
    input  logic [gpl_pkg::PIN_COUNT-1:0]   i_pin_levels_in,
    output gpl_pkg::t_gpl_sts               o_sts,
    output logic [gpl_pkg::BUS_W-1:0]       o_read_data,
    output logic [gpl_pkg::PIN_COUNT-1:0]   o_pin_drive_out,
    output logic                            o_bad_register
);
    import gpl_pkg::*;

    logic [BUS_W-1:0]     r_cfg_low, n_cfg_low;
    logic [BUS_W-1:0]     r_cfg_high, n_cfg_high;
    logic [PIN_COUNT-1:0] r_out_word, n_out_word;
    logic [PIN_COUNT-1:0] r_lock_bits;
    logic [BUS_W-1:0]     r_rdata, n_rdata;
    logic                 r_bad;
    logic [BUS_W-1:0]     mask_low, mask_high;
    logic                 is_wr;

    always_comb begin
        for (int i = 0; i < PIN_COUNT / 2; i++) begin
            mask_low[4*i +: 4]  = {4{i_cmd.lock_key & r_lock_bits[i]}};
            mask_high[4*i +: 4] = {4{i_cmd.lock_key & r_lock_bits[i + PIN_COUNT/2]}};
        end
    end

    assign is_wr            = i_cmd.load & (i_mode == MODE_WRITE);
    assign o_sts.bits_match = (i_write_data[PIN_COUNT-1:0] == r_lock_bits);

    always_comb begin
        n_cfg_low  = r_cfg_low;
        n_cfg_high = r_cfg_high;
        n_out_word = r_out_word;
        if (is_wr) begin
            case (i_reg_index)
                REG_CFG_LOW:  n_cfg_low  = (r_cfg_low & mask_low)
                                         | (i_write_data & ~mask_low);
                REG_CFG_HIGH: n_cfg_high = (r_cfg_high & mask_high)
                                         | (i_write_data & ~mask_high);
                REG_OUT:      n_out_word = i_write_data[PIN_COUNT-1:0];
                REG_SETRESET: n_out_word = (r_out_word & ~i_write_data[BUS_W-1:PIN_COUNT])
                                         | i_write_data[PIN_COUNT-1:0];
                REG_RESET:    n_out_word = r_out_word & ~i_write_data[PIN_COUNT-1:0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        n_rdata = '0;
        if (i_mode == MODE_READ) begin
            unique case (i_reg_index)
                REG_CFG_LOW:  n_rdata = r_cfg_low;
                REG_CFG_HIGH: n_rdata = r_cfg_high;
                REG_IN:       n_rdata = {{(BUS_W-PIN_COUNT){1'b0}}, i_pin_levels_in};
                REG_OUT:      n_rdata = {{(BUS_W-PIN_COUNT){1'b0}}, r_out_word};
                REG_LOCK:     n_rdata = {{(BUS_W-PIN_COUNT-1){1'b0}}, i_cmd.lock_key,
                                         r_lock_bits};
                default:      n_rdata = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_low   <= CFG_RESET;
            r_cfg_high  <= CFG_RESET;
            r_out_word  <= '0;
            r_lock_bits <= '0;
        end else begin
            r_cfg_low  <= n_cfg_low;
            r_cfg_high <= n_cfg_high;
            r_out_word <= n_out_word;
            if (i_cmd.lock_bits_we) begin
                r_lock_bits <= i_write_data[PIN_COUNT-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rdata <= n_rdata;
            r_bad   <= (i_reg_index == REG_BAD);
        end
    end

    assign o_read_data     = r_rdata;
    assign o_pin_drive_out = r_out_word;
    assign o_bad_register  = r_bad;

endmodule
